// ----- rtl/htsf_pkg.sv -----
`timescale 1ns / 1ps

package htsf_pkg;

  // Fixed-point widths: values are signed Q24.16, sums are carried wide.
  localparam int VAL_W = 40;
  localparam int ACC_W = 60;
  localparam int DIFF_W = 42;
  localparam int WGT_W = 16;
  localparam int MOP_W = 22;
  localparam int MUL_W = WGT_W + 1 + MOP_W;
  localparam int MUL_SPLIT = 21;
  localparam int FRAC_BITS = 16;
  localparam int HORIZON_W = 5;
  localparam int STEP_W = 5;

  localparam int HORIZON_MAX_DEF = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  // Configuration port.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZON = 2'd2;

  localparam logic [WGT_W-1:0] ALPHA_RST = 16'd32768;
  localparam logic [WGT_W-1:0] BETA_RST = 16'd32768;
  localparam logic [HORIZON_W-1:0] HORIZON_RST = 5'd1;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = 60'sd32768;
  localparam logic signed [ACC_W-1:0] MAX40 = 60'sd549755813887;
  localparam logic signed [ACC_W-1:0] MIN40 = -60'sd549755813888;

  // Series phase codes.
  localparam logic [1:0] PH_NONE = 2'd0;
  localparam logic [1:0] PH_ONE = 2'd1;
  localparam logic [1:0] PH_RUN = 2'd2;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL_LO,
    ALU_MUL_HI
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    logic [ACC_W-1:0] a;
    logic [ACC_W-1:0] b;
    logic [WGT_W-1:0] w;
    logic [MOP_W-1:0] m;
  } alu_req_t;

  function automatic logic signed [ACC_W-1:0] sext_val(input logic [VAL_W-1:0] v);
    return $signed({{(ACC_W - VAL_W){v[VAL_W-1]}}, v});
  endfunction

  function automatic logic [VAL_W-1:0] sat40(input logic signed [ACC_W-1:0] v);
    logic [VAL_W-1:0] r;
    if (v > MAX40) begin
      r = MAX40[VAL_W-1:0];
    end else if (v < MIN40) begin
      r = MIN40[VAL_W-1:0];
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/htsf_alu.sv -----
`timescale 1ns / 1ps

module htsf_alu import htsf_pkg::*; (
  input  alu_req_t                 req,
  output logic signed [ACC_W-1:0]  result
);

  logic signed [MUL_W-1:0] prod;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] term;

  // A 42-bit operand is multiplied in two halves of 21 bits on successive cycles.
  assign prod = $signed({1'b0, req.w}) * $signed(req.m);
  assign prod_ext = $signed({{(ACC_W - MUL_W){prod[MUL_W-1]}}, prod});

  always_comb begin
    case (req.op)
      ALU_ADD:    term = $signed(req.b);
      ALU_SUB:    term = -$signed(req.b);
      ALU_MUL_LO: term = prod_ext;
      ALU_MUL_HI: term = prod_ext <<< MUL_SPLIT;
      default:    term = $signed(req.b);
    endcase
  end

  assign result = $signed(req.a) + term;

endmodule

// ----- rtl/holt_trend_smoothing_forecaster_core.sv -----
`timescale 1ns / 1ps

// Sequence: a sample that opens a series goes straight to the forecast steps; the second
// sample first sets the trend (S_WARM), and it and any later one then update level and trend.
// A new sample is taken only in S_IDLE, after the last forecast of the horizon is sent;
// forecasts go out one per cycle unless out_ready stalls them; one shared
// adder/multiplier does one operation per cycle.
// Reset: rst clears the series phase, the estimates and restores the default registers.
module holt_trend_smoothing_forecaster_core import htsf_pkg::*; #(
  parameter int HORIZON_MAX = HORIZON_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   series_start,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VAL_W-1:0]       forecast_value,
  output logic [STEP_W-1:0]      step_index,
  output logic                   last_step,
  output logic                   warming_up,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int KW = $clog2(HORIZON_MAX + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_WARM,
    S_SUM,
    S_DIFF,
    S_LMUL_LO,
    S_LMUL_HI,
    S_LRND,
    S_TDIF,
    S_TSUB,
    S_TMUL_LO,
    S_TMUL_HI,
    S_TRND,
    S_FC0,
    S_EMIT
  } state_t;

  state_t state;

  logic [WGT_W-1:0]     alpha;
  logic [WGT_W-1:0]     beta;
  logic [HORIZON_W-1:0] horizon;

  logic [VAL_W-1:0]        level;
  logic [VAL_W-1:0]        level_prev;
  logic [VAL_W-1:0]        trend;
  logic [1:0]              phase;
  logic signed [ACC_W-1:0] xq;
  logic signed [ACC_W-1:0] r;
  logic [DIFF_W-1:0]       d;
  logic [KW-1:0]           k;
  logic [KW-1:0]           n_eff;

  alu_req_t                req;
  logic signed [ACC_W-1:0] alu_res;
  logic signed [ACC_W-1:0] xq_in;
  logic                    in_acc;
  logic                    out_free;

  htsf_alu u_alu (
    .req    (req),
    .result (alu_res)
  );

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign xq_in = $signed({{(ACC_W - SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample}) <<< FRAC_BITS;

  always_comb begin
    if (horizon == '0) begin
      n_eff = KW'(1);
    end else if (int'(horizon) > HORIZON_MAX) begin
      n_eff = KW'(HORIZON_MAX);
    end else begin
      n_eff = KW'(horizon);
    end
  end

  // Operand selection for the shared unit, one operation per sequencer step.
  always_comb begin
    req.op = ALU_ADD;
    req.a = r;
    req.b = sext_val(trend);
    req.w = alpha;
    req.m = $signed({1'b0, d[MUL_SPLIT-1:0]});
    case (state)
      S_WARM: begin
        req.op = ALU_SUB;
        req.a = xq;
        req.b = sext_val(level);
      end
      S_SUM, S_FC0: begin
        req.a = sext_val(level);
      end
      S_DIFF: begin
        req.op = ALU_SUB;
        req.a = xq;
        req.b = r;
      end
      S_LMUL_LO: begin
        req.op = ALU_MUL_LO;
        req.a = r <<< FRAC_BITS;
      end
      S_LMUL_HI: begin
        req.op = ALU_MUL_HI;
        req.m = {d[DIFF_W-1], d[DIFF_W-1:MUL_SPLIT]};
      end
      S_LRND, S_TRND: begin
        req.b = ROUND_HALF;
      end
      S_TDIF: begin
        req.op = ALU_SUB;
        req.a = sext_val(level);
        req.b = sext_val(level_prev);
      end
      S_TSUB: begin
        req.op = ALU_SUB;
      end
      S_TMUL_LO: begin
        req.op = ALU_MUL_LO;
        req.a = sext_val(trend) <<< FRAC_BITS;
        req.w = beta;
      end
      S_TMUL_HI: begin
        req.op = ALU_MUL_HI;
        req.w = beta;
        req.m = {d[DIFF_W-1], d[DIFF_W-1:MUL_SPLIT]};
      end
      default: begin
        req.op = ALU_ADD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      alpha <= ALPHA_RST;
      beta <= BETA_RST;
      horizon <= HORIZON_RST;
      level <= '0;
      trend <= '0;
      phase <= PH_NONE;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ALPHA:   alpha <= cfg_data[WGT_W-1:0];
          CFG_BETA:    beta <= cfg_data[WGT_W-1:0];
          CFG_HORIZON: horizon <= cfg_data[HORIZON_W-1:0];
          default:     ;
        endcase
      end

      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            xq <= xq_in;
            if (series_start || phase == PH_NONE) begin
              level <= sat40(xq_in);
              trend <= '0;
              phase <= PH_ONE;
              state <= S_FC0;
            end else if (phase == PH_ONE) begin
              state <= S_WARM;
            end else begin
              state <= S_SUM;
            end
          end
        end
        S_WARM: begin
          trend <= sat40(alu_res);
          phase <= PH_RUN;
          state <= S_SUM;
        end
        S_SUM: begin
          r <= alu_res;
          state <= S_DIFF;
        end
        S_DIFF: begin
          d <= alu_res[DIFF_W-1:0];
          state <= S_LMUL_LO;
        end
        S_LMUL_LO: begin
          r <= alu_res;
          state <= S_LMUL_HI;
        end
        S_LMUL_HI: begin
          r <= alu_res;
          state <= S_LRND;
        end
        S_LRND: begin
          level_prev <= level;
          level <= sat40(alu_res >>> FRAC_BITS);
          state <= S_TDIF;
        end
        S_TDIF: begin
          r <= alu_res;
          state <= S_TSUB;
        end
        S_TSUB: begin
          d <= alu_res[DIFF_W-1:0];
          state <= S_TMUL_LO;
        end
        S_TMUL_LO: begin
          r <= alu_res;
          state <= S_TMUL_HI;
        end
        S_TMUL_HI: begin
          r <= alu_res;
          state <= S_TRND;
        end
        S_TRND: begin
          trend <= sat40(alu_res >>> FRAC_BITS);
          state <= S_FC0;
        end
        S_FC0: begin
          r <= alu_res;
          k <= KW'(1);
          state <= S_EMIT;
        end
        S_EMIT: begin
          // The running sum steps on by one trend for each forecast beat sent.
          if (out_free) begin
            out_valid <= 1'b1;
            forecast_value <= sat40(r);
            step_index <= STEP_W'(k);
            last_step <= (k == n_eff);
            warming_up <= (phase == PH_ONE);
            r <= alu_res;
            if (k == n_eff) begin
              state <= S_IDLE;
            end else begin
              k <= k + KW'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("block took a sample while the previous one was still in work");

  a_no_output_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("forecast beat present straight after reset");

  a_step_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> step_index != '0)
    else $error("forecast beat with step index zero");

  a_last_matches_horizon: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_step |-> step_index == STEP_W'(n_eff))
    else $error("last forecast beat does not match the horizon");
`endif

endmodule
